[rtl/i2cmbe_pkg.sv]
// Package for the I2C master byte engine.
// Holds phase and command codes, field widths and the sequencer state type.
`default_nettype none

package i2cmbe_pkg;

    localparam int PhaseW = 5;

    localparam logic [PhaseW-1:0] PH_IDLE    = 5'd0;
    localparam logic [PhaseW-1:0] PH_ST0     = 5'd1;
    localparam logic [PhaseW-1:0] PH_ST1     = 5'd2;
    localparam logic [PhaseW-1:0] PH_ST2     = 5'd3;
    localparam logic [PhaseW-1:0] PH_ST3     = 5'd4;
    localparam logic [PhaseW-1:0] PH_SP0     = 5'd5;
    localparam logic [PhaseW-1:0] PH_SP1     = 5'd6;
    localparam logic [PhaseW-1:0] PH_SP2     = 5'd7;
    localparam logic [PhaseW-1:0] PH_WB_SDA  = 5'd8;
    localparam logic [PhaseW-1:0] PH_WB_SCLH = 5'd9;
    localparam logic [PhaseW-1:0] PH_WB_SCLL = 5'd10;
    localparam logic [PhaseW-1:0] PH_WA_REL  = 5'd11;
    localparam logic [PhaseW-1:0] PH_WA_SCLH = 5'd12;
    localparam logic [PhaseW-1:0] PH_WA_POLL = 5'd13;
    localparam logic [PhaseW-1:0] PH_WA_SP0  = 5'd14;
    localparam logic [PhaseW-1:0] PH_WA_SP1  = 5'd15;
    localparam logic [PhaseW-1:0] PH_WA_SP2  = 5'd16;
    localparam logic [PhaseW-1:0] PH_WA_END  = 5'd17;
    localparam logic [PhaseW-1:0] PH_RB_REL  = 5'd18;
    localparam logic [PhaseW-1:0] PH_RB_SCLH = 5'd19;
    localparam logic [PhaseW-1:0] PH_RB_SCLL = 5'd20;
    localparam logic [PhaseW-1:0] PH_RA_SDA  = 5'd21;
    localparam logic [PhaseW-1:0] PH_RA_SCLH = 5'd22;
    localparam logic [PhaseW-1:0] PH_RA_SCLL = 5'd23;

    localparam logic [2:0] FN_TICK  = 3'd0;
    localparam logic [2:0] FN_START = 3'd1;
    localparam logic [2:0] FN_STOP  = 3'd2;
    localparam logic [2:0] FN_WRITE = 3'd3;
    localparam logic [2:0] FN_READ  = 3'd4;

    localparam logic [7:0] ACK_TIMEOUT_RST = 8'd100;
    localparam logic [2:0] LAST_BIT        = 3'd7;

    localparam int InDataW  = 16;
    localparam int OutDataW = 16;

    typedef struct packed {
        logic [PhaseW-1:0] phase;
        logic [2:0]        bit_idx;
        logic [7:0]        shift;
        logic [7:0]        poll;
        logic              nack;
        logic              scl;
        logic              sda;
        logic [7:0]        held_read;
        logic              held_ack;
        logic              held_to;
    } t_seq_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_step_flags;

    localparam t_seq_state SEQ_RST = '{
        phase:     PH_IDLE,
        bit_idx:   3'd0,
        shift:     8'd0,
        poll:      8'd0,
        nack:      1'b0,
        scl:       1'b1,
        sda:       1'b1,
        held_read: 8'd0,
        held_ack:  1'b0,
        held_to:   1'b0
    };

endpackage

`default_nettype wire

[rtl/i2cmbe_step.sv]
// One line phase of the I2C master sequencer, purely combinational.
// Depends on i2cmbe_pkg for phase codes and the state type.
`default_nettype none

module i2cmbe_step (
    input  var i2cmbe_pkg::t_seq_state  i_cur,
    input  wire logic [2:0]             i_func,
    input  wire logic [7:0]             i_data_byte,
    input  wire logic                   i_send_nack,
    input  wire logic                   i_sda_in,
    input  wire logic [7:0]             i_ack_timeout,
    output i2cmbe_pkg::t_seq_state      o_nxt,
    output i2cmbe_pkg::t_step_flags     o_flags
);

    i2cmbe_pkg::t_seq_state       s;
    logic [i2cmbe_pkg::PhaseW-1:0] nxt_ph;
    logic [2:0]                    bit_sel;

    always_comb begin
        s       = i_cur;
        nxt_ph  = i2cmbe_pkg::PH_IDLE;
        o_flags = '0;

        if (s.phase == i2cmbe_pkg::PH_IDLE) begin
            case (i_func)
                i2cmbe_pkg::FN_START: begin
                    s.phase   = i2cmbe_pkg::PH_ST0;
                    s.bit_idx = 3'd0;
                    s.poll    = 8'd0;
                end
                i2cmbe_pkg::FN_STOP: begin
                    s.phase   = i2cmbe_pkg::PH_SP0;
                    s.bit_idx = 3'd0;
                    s.poll    = 8'd0;
                end
                i2cmbe_pkg::FN_WRITE: begin
                    s.phase   = i2cmbe_pkg::PH_WB_SDA;
                    s.bit_idx = 3'd0;
                    s.poll    = 8'd0;
                    s.shift   = i_data_byte;
                end
                i2cmbe_pkg::FN_READ: begin
                    s.phase   = i2cmbe_pkg::PH_RB_REL;
                    s.bit_idx = 3'd0;
                    s.poll    = 8'd0;
                    s.shift   = 8'd0;
                    s.nack    = i_send_nack;
                end
                default: begin
                end
            endcase
        end

        bit_sel = i2cmbe_pkg::LAST_BIT - s.bit_idx;

        if (s.phase != i2cmbe_pkg::PH_IDLE) begin
            o_flags.busy = 1'b1;
            case (s.phase)
                i2cmbe_pkg::PH_ST0: begin s.sda = 1'b1; nxt_ph = i2cmbe_pkg::PH_ST1; end
                i2cmbe_pkg::PH_ST1: begin s.scl = 1'b1; nxt_ph = i2cmbe_pkg::PH_ST2; end
                i2cmbe_pkg::PH_ST2: begin s.sda = 1'b0; nxt_ph = i2cmbe_pkg::PH_ST3; end
                i2cmbe_pkg::PH_ST3: begin s.scl = 1'b0; end
                i2cmbe_pkg::PH_SP0: begin s.sda = 1'b0; nxt_ph = i2cmbe_pkg::PH_SP1; end
                i2cmbe_pkg::PH_SP1: begin s.scl = 1'b1; nxt_ph = i2cmbe_pkg::PH_SP2; end
                i2cmbe_pkg::PH_SP2: begin s.sda = 1'b1; end
                i2cmbe_pkg::PH_WB_SDA: begin
                    s.sda  = s.shift[bit_sel];
                    nxt_ph = i2cmbe_pkg::PH_WB_SCLH;
                end
                i2cmbe_pkg::PH_WB_SCLH: begin
                    s.scl  = 1'b1;
                    nxt_ph = i2cmbe_pkg::PH_WB_SCLL;
                end
                i2cmbe_pkg::PH_WB_SCLL: begin
                    s.scl = 1'b0;
                    if (s.bit_idx == i2cmbe_pkg::LAST_BIT) begin
                        s.bit_idx = 3'd0;
                        nxt_ph    = i2cmbe_pkg::PH_WA_REL;
                    end else begin
                        s.bit_idx = s.bit_idx + 3'd1;
                        nxt_ph    = i2cmbe_pkg::PH_WB_SDA;
                    end
                end
                i2cmbe_pkg::PH_WA_REL: begin
                    s.sda  = 1'b1;
                    nxt_ph = i2cmbe_pkg::PH_WA_SCLH;
                end
                i2cmbe_pkg::PH_WA_SCLH: begin
                    s.scl  = 1'b1;
                    s.poll = 8'd0;
                    nxt_ph = i2cmbe_pkg::PH_WA_POLL;
                end
                i2cmbe_pkg::PH_WA_POLL: begin
                    if (!i_sda_in) begin
                        s.held_ack = 1'b0;
                        s.held_to  = 1'b0;
                        nxt_ph     = i2cmbe_pkg::PH_WA_END;
                    end else if (s.poll >= i_ack_timeout) begin
                        s.held_ack = 1'b1;
                        s.held_to  = 1'b1;
                        nxt_ph     = i2cmbe_pkg::PH_WA_SP0;
                    end else begin
                        s.poll = s.poll + 8'd1;
                        nxt_ph = i2cmbe_pkg::PH_WA_POLL;
                    end
                end
                i2cmbe_pkg::PH_WA_SP0: begin
                    s.sda  = 1'b0;
                    nxt_ph = i2cmbe_pkg::PH_WA_SP1;
                end
                i2cmbe_pkg::PH_WA_SP1: begin
                    s.scl  = 1'b1;
                    nxt_ph = i2cmbe_pkg::PH_WA_SP2;
                end
                i2cmbe_pkg::PH_WA_SP2: begin
                    s.sda  = 1'b1;
                    nxt_ph = i2cmbe_pkg::PH_WA_END;
                end
                i2cmbe_pkg::PH_WA_END: begin s.scl = 1'b0; end
                i2cmbe_pkg::PH_RB_REL: begin
                    s.sda  = 1'b1;
                    nxt_ph = i2cmbe_pkg::PH_RB_SCLH;
                end
                i2cmbe_pkg::PH_RB_SCLH: begin
                    s.scl = 1'b1;
                    if (i_sda_in) begin
                        s.shift[bit_sel] = 1'b1;
                    end
                    nxt_ph = i2cmbe_pkg::PH_RB_SCLL;
                end
                i2cmbe_pkg::PH_RB_SCLL: begin
                    s.scl = 1'b0;
                    if (s.bit_idx == i2cmbe_pkg::LAST_BIT) begin
                        s.bit_idx   = 3'd0;
                        s.held_read = s.shift;
                        nxt_ph      = i2cmbe_pkg::PH_RA_SDA;
                    end else begin
                        s.bit_idx = s.bit_idx + 3'd1;
                        nxt_ph    = i2cmbe_pkg::PH_RB_SCLH;
                    end
                end
                i2cmbe_pkg::PH_RA_SDA: begin
                    s.sda  = s.nack;
                    nxt_ph = i2cmbe_pkg::PH_RA_SCLH;
                end
                i2cmbe_pkg::PH_RA_SCLH: begin
                    s.scl  = 1'b1;
                    nxt_ph = i2cmbe_pkg::PH_RA_SCLL;
                end
                i2cmbe_pkg::PH_RA_SCLL: begin s.scl = 1'b0; end
                default: begin
                end
            endcase
            s.phase      = nxt_ph;
            o_flags.done = (nxt_ph == i2cmbe_pkg::PH_IDLE);
        end

        o_nxt = s;
    end

endmodule

`default_nettype wire

[rtl/i2c_master_byte_engine_unit.sv]
// The result of an input transfer is registered and shows on the output register in the next cycle.
// Throughput: one item per cycle while the output is not stalled; the phase step is a single combinational pass.
// Input is taken while the output register is empty or being drained.
// Reset (synchronous, active low): idle phase, both lines released, held results
// zero, ack timeout 100, output empty.
`default_nettype none

module i2c_master_byte_engine_unit (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [7:0]                       i_cfg_wdata,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // tdata: data_byte[7:0], send_nack[8], sda_in[9], zero[15:10]
    input  wire logic [i2cmbe_pkg::InDataW-1:0]   s_axis_tdata,
    // tuser: func[2:0]
    input  wire logic [2:0]                       s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // tdata: scl_out[0], sda_out[1], busy_res[2], done_res[3], read_byte[11:4],
    //        ack_bit[12], timed_out[13], zero[15:14]
    output logic [i2cmbe_pkg::OutDataW-1:0]       m_axis_tdata
);

    i2cmbe_pkg::t_seq_state  r_st;
    i2cmbe_pkg::t_seq_state  n_st;
    i2cmbe_pkg::t_step_flags w_flags;
    logic [7:0]              r_ack_timeout;
    logic                    r_out_vld;
    logic [i2cmbe_pkg::OutDataW-1:0] r_out_data;
    logic                    w_in_xfer;

    assign s_axis_tready = !r_out_vld || m_axis_tready;
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;

    i2cmbe_step u_step (
        .i_cur         (r_st),
        .i_func        (s_axis_tuser),
        .i_data_byte   (s_axis_tdata[7:0]),
        .i_send_nack   (s_axis_tdata[8]),
        .i_sda_in      (s_axis_tdata[9]),
        .i_ack_timeout (r_ack_timeout),
        .o_nxt         (n_st),
        .o_flags       (w_flags)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_timeout <= i2cmbe_pkg::ACK_TIMEOUT_RST;
        end else if (i_cfg_we) begin
            r_ack_timeout <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= i2cmbe_pkg::SEQ_RST;
            r_out_vld <= 1'b0;
        end else begin
            if (w_in_xfer) begin
                r_st      <= n_st;
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_out_data <= {2'b00, n_st.held_to, n_st.held_ack, n_st.held_read,
                           w_flags.done, w_flags.busy, n_st.sda, n_st.scl};
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

[rtl/i2cmbe_checker.sv]
// Port-level checker for the I2C master byte engine, bound to the top level.
// Depends on i2cmbe_pkg for the stream widths.
`default_nettype none

module i2cmbe_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_s_tready,
    input wire logic                            i_m_tvalid,
    input wire logic                            i_m_tready,
    input wire logic [i2cmbe_pkg::OutDataW-1:0] i_m_tdata
);

    // hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tready) |=> (i_m_tvalid && $stable(i_m_tdata)))
        else $error("stalled result changed");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_m_tvalid |-> i_s_tready)
        else $error("input not ready with empty output");

    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> !(i_m_tdata[3] && !i_m_tdata[2]))
        else $error("done without busy");

    a_tmo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> !(i_m_tdata[13] && !i_m_tdata[12]))
        else $error("timeout without nack");

    a_rst: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_m_tvalid)
        else $error("output valid after reset");

endmodule

bind i2c_master_byte_engine_unit i2cmbe_checker u_i2cmbe_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata)
);

`default_nettype wire
